[design/mkwx_pkg.sv]
// constants for the minstd keystream word xor block
// holds word widths, minstd step constants and register indexes; no dependencies

package mkwx_pkg;

    localparam int WordW      = 32;
    localparam int IndexW     = 30;
    localparam int CountW     = 3;
    localparam int QuotW      = 16;
    localparam int CfgIndexW  = 1;
    localparam int StepsPerWord = 4;
    localparam int ByteW      = 8;
    localparam int BytesPerWordI = WordW / ByteW;

    // minstd multiplier and schrage quotient
    localparam logic [WordW-1:0] MsA   = 32'd48271;
    localparam logic [WordW-1:0] MsQ   = 32'd44488;
    localparam logic [WordW-1:0] MsFix = 32'h7FFF_FFFF;

    // largest quotient magnitude, reached at -2^31
    localparam logic [QuotW-1:0] MaxQuot = 16'd48271;

    // reciprocal of the schrage quotient, scaled by 2^RecipShift, rounded down
    localparam int RecipShift = 47;
    localparam logic [63:0] RecipWide = (64'd1 << RecipShift) / 64'd44488;
    localparam logic [WordW-1:0] MsRecip = RecipWide[WordW-1:0];

    localparam logic [CountW-1:0] BytesPerWord = CountW'(BytesPerWordI);

    // register indexes
    localparam logic [CfgIndexW-1:0] CfgTotalSize  = 1'b0;
    localparam logic [CfgIndexW-1:0] CfgFileOffset = 1'b1;

endpackage

[design/minstd_keystream_word_xor.sv]
// top level of the minstd keystream word xor decryptor
// uses mkwx_pkg for widths, step constants and register indexes

// Decrypts one archive entry as little-endian 32-bit words. Word i is XORed
// with a key built from four chained MINSTD steps (multiplier 48271, Schrage
// form) seeded with (total_size ^ file_offset) + i; bytes past total_size pass
// unchanged and the word count wraps to zero after the last word. A single
// 32x32 multiplier with one adder behind it runs each step through its phases
// (product 48271*x, quotient estimate by reciprocal, quotient correction,
// update), and the four steps of a word run one after another. A new word is
// taken only once the last one has had its result loaded, and with total_size
// zero the word skips the step loop. s_ready is high only
// while the block is idle. The result sits in an output register, so the block
// goes back to idle and takes the next word while that beat waits on m_ready;
// only a second result waits for the first to drain. Configuration writes are
// always accepted (cfg_ready tied high) and must be done between entries;
// cfg_index 0 is total_size, 1 is file_offset. Writes leave the word count
// alone; if total_size is lowered so that the count lies at or past the end,
// the next word is taken as the first of the entry.

module minstd_keystream_word_xor
    import mkwx_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // encrypted word in
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WordW-1:0]     s_data_word,

    // decrypted word out
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WordW-1:0]     m_plain_word,
    output logic [CountW-1:0]    m_bytes_valid,
    output logic                 m_last_word,

    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [WordW-1:0]     cfg_data
);

    localparam int StepW = $clog2(StepsPerWord);
    localparam logic [StepW-1:0] LastStep = StepW'(StepsPerWord - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FIN
    } state_t;

    // phases of one minstd step
    typedef enum logic [1:0] {
        PH_ABS,
        PH_QEST,
        PH_QFIX,
        PH_UPD
    } phase_t;

    // control
    state_t              state_reg,  state_next;
    phase_t              phase_reg,  phase_next;
    logic [StepW-1:0]    step_reg,   step_next;
    logic [IndexW-1:0]   word_index_reg, word_index_next;
    logic                m_valid_reg, m_valid_next;

    // configuration
    logic [WordW-1:0]    total_size_reg, total_size_next;
    logic [WordW-1:0]    file_offset_reg, file_offset_next;

    // payload and step datapath
    logic [WordW-1:0]    data_reg,   data_next;
    logic [CountW-1:0]   n_reg,      n_next;
    logic                last_reg,   last_next;
    logic [WordW-1:0]    x_reg,      x_next;
    logic [WordW-1:0]    a_reg,      a_next;
    logic                neg_reg,    neg_next;
    logic [QuotW-1:0]    q_reg,      q_next;
    logic [WordW-1:0]    p1_reg,     p1_next;
    logic [WordW-1:0]    key_reg,    key_next;
    logic [WordW-1:0]    m_plain_word_reg,  m_plain_word_next;
    logic [CountW-1:0]   m_bytes_valid_reg, m_bytes_valid_next;
    logic                m_last_word_reg,   m_last_word_next;

    // shared multiplier
    logic [WordW-1:0]    mul_a, mul_b;
    logic [2*WordW-1:0]  mul_prod;

    // entry position at accept
    logic [WordW-1:0]    done_bytes;
    logic [WordW:0]      rem_diff;
    logic                past_end;
    logic [IndexW-1:0]   idx_eff;
    logic [WordW-1:0]    remaining;
    logic                acc_last;
    logic [CountW-1:0]   acc_n;
    logic [WordW-1:0]    seed;

    // step arithmetic
    logic [WordW-1:0]    rem0;
    logic [WordW-1:0]    q_signed;
    logic [WordW-1:0]    s_raw;
    logic [WordW-1:0]    x_new;
    logic [WordW-1:0]    byte_mask;

    logic                in_beat;
    logic                out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_plain_word  = m_plain_word_reg;
    assign m_bytes_valid = m_bytes_valid_reg;
    assign m_last_word   = m_last_word_reg;

    // where the next word sits in the entry
    assign done_bytes = {word_index_reg, 2'b00};
    assign rem_diff   = {1'b0, total_size_reg} - {1'b0, done_bytes};
    assign past_end   = rem_diff[WordW] || (rem_diff[WordW-1:0] == '0);
    assign idx_eff    = past_end ? '0 : word_index_reg;
    assign remaining  = past_end ? total_size_reg : rem_diff[WordW-1:0];
    assign acc_last   = (remaining <= WordW'(BytesPerWordI));
    assign acc_n      = acc_last ? remaining[CountW-1:0] : BytesPerWord;
    assign seed       = (total_size_reg ^ file_offset_reg) + {2'b00, idx_eff};

    // operand select for the one multiplier
    always_comb begin
        unique case (phase_reg)
            PH_ABS: begin
                mul_a = x_reg;
                mul_b = MsA;
            end
            PH_QEST: begin
                mul_a = a_reg;
                mul_b = MsRecip;
            end
            PH_QFIX: begin
                mul_a = {{(WordW-QuotW){1'b0}}, q_reg};
                mul_b = MsQ;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // remainder of the estimated quotient, below twice the divisor
    assign rem0 = a_reg - mul_prod[WordW-1:0];

    // 48271*x - q*(2^31-1) taken mod 2^32, equal to the schrage form
    assign q_signed = neg_reg ? (WordW'(0) - {{(WordW-QuotW){1'b0}}, q_reg})
                              : {{(WordW-QuotW){1'b0}}, q_reg};
    assign s_raw = p1_reg + q_signed - {q_reg[0], {(WordW-1){1'b0}}};
    // non-positive results wrap back into range
    assign x_new = ((s_raw == '0) || s_raw[WordW-1]) ? (s_raw + MsFix) : s_raw;

    // one mask byte for each decrypted byte
    always_comb begin
        for (int i = 0; i < BytesPerWordI; i++) begin
            byte_mask[i*ByteW +: ByteW] = (n_reg > CountW'(i)) ? '1 : '0;
        end
    end

    always_comb begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        step_next          = step_reg;
        word_index_next    = word_index_reg;
        m_valid_next       = m_valid_reg;
        total_size_next    = total_size_reg;
        file_offset_next   = file_offset_reg;
        data_next          = data_reg;
        n_next             = n_reg;
        last_next          = last_reg;
        x_next             = x_reg;
        a_next             = a_reg;
        neg_next           = neg_reg;
        q_next             = q_reg;
        p1_next            = p1_reg;
        key_next           = key_reg;
        m_plain_word_next  = m_plain_word_reg;
        m_bytes_valid_next = m_bytes_valid_reg;
        m_last_word_next   = m_last_word_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CfgTotalSize:  total_size_next  = cfg_data;
                CfgFileOffset: file_offset_next = cfg_data;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    data_next = s_data_word;
                    if (total_size_reg == '0) begin
                        // empty entry: word passes through
                        n_next          = '0;
                        last_next       = 1'b0;
                        word_index_next = '0;
                        state_next      = ST_FIN;
                    end else begin
                        n_next          = acc_n;
                        last_next       = acc_last;
                        word_index_next = acc_last ? '0 : (idx_eff + IndexW'(1));
                        x_next          = seed;
                        step_next       = '0;
                        phase_next      = PH_ABS;
                        state_next      = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                unique case (phase_reg)
                    PH_ABS: begin
                        p1_next    = mul_prod[WordW-1:0];
                        neg_next   = x_reg[WordW-1];
                        a_next     = x_reg[WordW-1] ? (WordW'(0) - x_reg) : x_reg;
                        phase_next = PH_QEST;
                    end
                    PH_QEST: begin
                        q_next     = mul_prod[RecipShift +: QuotW];
                        phase_next = PH_QFIX;
                    end
                    PH_QFIX: begin
                        q_next     = q_reg + QuotW'(rem0 >= MsQ);
                        phase_next = PH_UPD;
                    end
                    PH_UPD: begin
                        x_next     = x_new;
                        key_next   = {key_reg[WordW-ByteW-1:0], x_new[ByteW-1:0]};
                        phase_next = PH_ABS;
                        step_next  = step_reg + StepW'(1);
                        if (step_reg == LastStep) begin
                            state_next = ST_FIN;
                        end
                    end
                    default: ;
                endcase
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_plain_word_next  = data_reg ^ (key_reg & byte_mask);
                    m_bytes_valid_next = n_reg;
                    m_last_word_next   = last_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_ABS;
            step_reg        <= '0;
            word_index_reg  <= '0;
            m_valid_reg     <= 1'b0;
            total_size_reg  <= '0;
            file_offset_reg <= '0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            step_reg        <= step_next;
            word_index_reg  <= word_index_next;
            m_valid_reg     <= m_valid_next;
            total_size_reg  <= total_size_next;
            file_offset_reg <= file_offset_next;
        end
        data_reg          <= data_next;
        n_reg             <= n_next;
        last_reg          <= last_next;
        x_reg             <= x_next;
        a_reg             <= a_next;
        neg_reg           <= neg_next;
        q_reg             <= q_next;
        p1_reg            <= p1_next;
        key_reg           <= key_next;
        m_plain_word_reg  <= m_plain_word_next;
        m_bytes_valid_reg <= m_bytes_valid_next;
        m_last_word_reg   <= m_last_word_next;
    end

`ifndef SYNTHESIS
    // a word in work blocks the input until its result is loaded
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_ready)
        else $error("input taken again right after a beat");

    // the corrected quotient never exceeds its bound at -2^31
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) && (phase_reg == PH_UPD) |-> (q_reg <= MaxQuot))
        else $error("schrage quotient out of range");

    // the step result is always a positive 31-bit value
    a_step_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) && (phase_reg == PH_UPD)
            |-> (!x_new[WordW-1] && (x_new != '0)))
        else $error("minstd step left range");

    // the count wraps after the last word of an entry
    a_wrap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && (total_size_reg != '0) && acc_last |=> (word_index_reg == '0))
        else $error("word count not cleared after last word");

    // a last-word beat always decrypts at least one byte
    a_last_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_word |-> (m_bytes_valid != '0)
            && (m_bytes_valid <= BytesPerWord))
        else $error("bad byte count on last word");
`endif

endmodule

[dv/mkwx_checker.sv]
// checker for the minstd keystream word xor decryptor: predicts each decrypted beat
// and compares it with the result channel; depends on mkwx_pkg for widths and indexes
`timescale 1ns / 1ps

module mkwx_checker
    import mkwx_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [WordW-1:0]     s_data_word,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [WordW-1:0]     m_plain_word,
    input  logic [CountW-1:0]    m_bytes_valid,
    input  logic                 m_last_word,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [WordW-1:0]     cfg_data,
    output int                   mismatch_count,
    output int                   words_pending,
    output int                   words_checked,
    output int                   entry_ends,
    output int                   passthru_words
);

    localparam longint MinstdMul = 48271;
    localparam longint SchrageQ  = 44488;
    localparam longint SchrageR  = 3399;

    typedef struct packed {
        logic [WordW-1:0]  plain;
        logic [CountW-1:0] nbytes;
        logic              last;
    } plain_beat_t;

    logic [WordW-1:0]  size_q;
    logic [WordW-1:0]  offset_q;
    logic [IndexW-1:0] word_count;
    plain_beat_t       plain_queue[$];
    plain_beat_t       want;
    int                errs;
    int                checked;
    int                ends;
    int                passthru;

    function automatic logic [WordW-1:0] park_miller_next(input logic [WordW-1:0] x);
        longint sx, quo, rem, prod;
        logic [WordW-1:0] u;
        sx   = longint'($signed(x));
        quo  = sx / SchrageQ;
        rem  = sx - quo * SchrageQ;
        prod = MinstdMul * rem - SchrageR * quo;
        u    = prod[WordW-1:0];
        if (u == '0 || u[WordW-1])
            u = u + MsFix;
        return u;
    endfunction

    function automatic logic [WordW-1:0] keystream_word(input logic [WordW-1:0] seed);
        logic [WordW-1:0] st1, st2, st3, st4;
        st1 = park_miller_next(seed);
        st2 = park_miller_next(st1);
        st3 = park_miller_next(st2);
        st4 = park_miller_next(st3);
        return {st1[7:0], st2[7:0], st3[7:0], st4[7:0]};
    endfunction

    // advances the word counter as a side effect
    function automatic plain_beat_t decrypt_word(input logic [WordW-1:0] cipher);
        plain_beat_t       beat;
        longint            consumed;
        longint            left;
        logic              at_end;
        logic [CountW-1:0] nbytes;
        logic [WordW-1:0]  mask;
        logic [WordW-1:0]  key;
        if (size_q == '0) begin
            beat.plain  = cipher;
            beat.nbytes = '0;
            beat.last   = 1'b0;
            word_count  = '0;
            return beat;
        end
        consumed = longint'({word_count, 2'b00});
        if (consumed >= longint'(size_q)) begin
            // counter stranded past a shrunken entry: restart at word zero
            word_count = '0;
            consumed   = 0;
        end
        left   = longint'(size_q) - consumed;
        at_end = (left <= 4);
        nbytes = at_end ? CountW'(left) : BytesPerWord;
        mask   = (nbytes == BytesPerWord) ? '1 : ((WordW'(1) << (8 * nbytes)) - 1);
        key    = keystream_word((size_q ^ offset_q) + {2'b00, word_count});
        beat.plain  = cipher ^ (key & mask);
        beat.nbytes = nbytes;
        beat.last   = at_end;
        word_count  = at_end ? '0 : word_count + 1'b1;
        return beat;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            size_q     = '0;
            offset_q   = '0;
            word_count = '0;
            plain_queue.delete();
            errs       = 0;
            checked    = 0;
            ends       = 0;
            passthru   = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CfgTotalSize:  size_q = cfg_data;
                    CfgFileOffset: offset_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                plain_queue.push_back(decrypt_word(s_data_word));
            if (m_valid && m_ready) begin
                if (plain_queue.size() == 0) begin
                    $error("unexpected result beat: plain_word %h bytes_valid %0d last_word %b",
                           m_plain_word, m_bytes_valid, m_last_word);
                    errs++;
                end else begin
                    want = plain_queue.pop_front();
                    checked++;
                    if (want.last) ends++;
                    if (want.nbytes == '0) passthru++;
                    if (m_plain_word !== want.plain) begin
                        $error("plain_word mismatch: expected %h, actual %h",
                               want.plain, m_plain_word);
                        errs++;
                    end
                    if (m_bytes_valid !== want.nbytes) begin
                        $error("bytes_valid mismatch: expected %0d, actual %0d",
                               want.nbytes, m_bytes_valid);
                        errs++;
                    end
                    if (m_last_word !== want.last) begin
                        $error("last_word mismatch: expected %b, actual %b",
                               want.last, m_last_word);
                        errs++;
                    end
                end
            end
        end
        mismatch_count <= errs;
        words_pending  <= plain_queue.size();
        words_checked  <= checked;
        entry_ends     <= ends;
        passthru_words <= passthru;
    end

endmodule

[dv/testbench.sv]
// top of the minstd keystream word xor testbench: clock, reset, stimulus and verdict
// instantiates minstd_keystream_word_xor and mkwx_checker; uses mkwx_pkg
`timescale 1ns / 1ps

module testbench;
    import mkwx_pkg::*;

    localparam int     RandomWords = 1100;
    localparam longint RunLimitNs  = 5_000_000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [WordW-1:0]     s_data_word;
    logic                 m_valid;
    logic                 m_ready;
    logic [WordW-1:0]     m_plain_word;
    logic [CountW-1:0]    m_bytes_valid;
    logic                 m_last_word;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index;
    logic [WordW-1:0]     cfg_data;

    int mismatch_count;
    int words_pending;
    int words_checked;
    int entry_ends;
    int passthru_words;

    // idling on both sides, switched off for one long stretch
    logic idle_en;
    int   words_sent;
    int   reg_writes;

    minstd_keystream_word_xor u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_plain_word  (m_plain_word),
        .m_bytes_valid (m_bytes_valid),
        .m_last_word   (m_last_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mkwx_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_word    (s_data_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_plain_word   (m_plain_word),
        .m_bytes_valid  (m_bytes_valid),
        .m_last_word    (m_last_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending),
        .words_checked  (words_checked),
        .entry_ends     (entry_ends),
        .passthru_words (passthru_words)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #(RunLimitNs);
        $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure, random per cycle while idling is on
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= idle_en ? ($urandom_range(99) >= 33) : 1'b1;
        end
    end

    // one encrypted word beat; valid is left high so a back-to-back beat
    // never drops it within the same step
    task automatic push_cipher_word(input logic [WordW-1:0] w);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(99) < 33)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_word <= w;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        idle_en <= !(words_sent >= 400 && words_sent < 650);
    endtask

    // hold the sender off until every predicted word has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
    endtask

    // one register write beat; cfg_valid is lowered by the caller
    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [WordW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        reg_writes++;
    endtask

    // registers only change once the block has gone quiet
    task automatic program_entry(input logic set_size, input logic [WordW-1:0] size,
                                 input logic set_offset, input logic [WordW-1:0] offset);
        wait_drained();
        if (set_size) write_reg(CfgTotalSize, size);
        if (set_offset) write_reg(CfgFileOffset, offset);
        cfg_valid <= 1'b0;
    endtask

    // random word, with all-zero and all-one words mixed in
    function automatic logic [WordW-1:0] pick_cipher();
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return '0;
        if (roll < 6) return '1;
        return $urandom();
    endfunction

    initial begin
        int               roll;
        int               count;
        logic [WordW-1:0] size;
        logic [WordW-1:0] offset;

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data_word <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CfgTotalSize;
        cfg_data    <= '0;
        idle_en     <= 1'b1;
        words_sent  = 0;
        reg_writes  = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---
        // empty entry after reset: words pass straight through
        push_cipher_word('0);
        push_cipher_word('1);

        // seven byte entry with an all-ones offset: full word then a three byte tail
        program_entry(1'b1, 32'd7, 1'b1, '1);
        push_cipher_word('1);
        push_cipher_word('1);

        // single word entries covering each tail length one to four
        for (int n = 1; n <= 4; n++) begin
            program_entry(1'b1, n, 1'b1, '0);
            push_cipher_word('1);
        end

        // seeds at the signed boundary: 0x7fffffff then 0x80000000
        program_entry(1'b1, '1, 1'b1, 32'h8000_0000);
        push_cipher_word(32'hA5A5_A5A5);
        push_cipher_word(32'h5A5A_5A5A);

        // seed zero with the count left at word two: size ^ offset is 0xfffffffe,
        // and the step result lands on zero and is fixed up
        program_entry(1'b1, 32'h1234_5678, 1'b1, 32'hEDCB_A986);
        push_cipher_word('0);

        // shrink the entry mid-stream: stranded counter restarts at word zero
        program_entry(1'b1, 32'd40, 1'b1, $urandom());
        repeat (5) push_cipher_word(pick_cipher());
        program_entry(1'b1, 32'd8, 1'b0, '0);
        push_cipher_word(pick_cipher());
        push_cipher_word(pick_cipher());

        // --- random part: mostly whole entries, some cut short or overrun ---
        words_sent = 0;
        while (words_sent < RandomWords) begin
            roll = $urandom_range(99);
            if (roll < 8)
                size = '0;
            else if (roll < 80)
                size = $urandom_range(1, 96);
            else if (roll < 90)
                size = $urandom_range(97, 4096);
            else
                size = $urandom();

            roll = $urandom_range(99);
            if (roll < 5)
                offset = '0;
            else if (roll < 10)
                offset = '1;
            else
                offset = $urandom();

            // occasionally keep the old offset so only the size moves
            program_entry(1'b1, size, ($urandom_range(9) != 0), offset);

            roll = $urandom_range(99);
            if (size == '0 || size > 96)
                count = $urandom_range(1, 12);
            else if (roll < 75)
                count = (size + 3) / 4;
            else if (roll < 90)
                count = $urandom_range(1, (size + 3) / 4);
            else
                count = (size + 3) / 4 + $urandom_range(1, 6);

            for (int k = 0; k < count; k++) begin
                // sender stalls until the pipeline empties now and then
                if ($urandom_range(39) == 0)
                    wait_drained();
                push_cipher_word(pick_cipher());
            end
        end

        // --- wind down ---
        wait_drained();
        repeat (40) @(posedge aclk);

        $display("run covered %0d decrypted words: %0d entry ends, %0d pass-through words",
                 words_checked, entry_ends, passthru_words);
        $display("register writes issued: %0d, across empty, tiny, boundary and huge sizes",
                 reg_writes);
        if (mismatch_count == 0 && words_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
